// File: src/sfrsd_pkg.sv
// Shared constants for the sync-framed range sensor decoder.
package sfrsd_pkg;

    localparam int RAW_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int Q4_W       = 12;
    localparam int CH_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int DIVIDEND_W = SCALE_W + 4;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = 5;

    localparam logic [RAW_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [RAW_W-1:0] SKIP_RAW  = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd2700;
    localparam logic [Q4_W-1:0]    OFFSET_RST = 12'd72;
    localparam logic [Q4_W-1:0]    LIMIT_RST  = 12'd1280;

endpackage

// File: src/sync_framed_range_sensor_decoder_core.sv
// Top level: frame capture, checksum, channel scan sequencer and result register.
// A byte that is not a checksum is taken whenever the sequencer is idle.
// A matching checksum starts a scan if some channel is not skipped: each channel is
// read and checked, a zero reading reports the limit, others pass the serial divider
// and each report waits for its transfer; no byte is taken until the scan ends.
// Reset clears frame state and the sequencer and loads default configuration.
module sync_framed_range_sensor_decoder_core #(
    parameter int CHANNELS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sfrsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfrsd_pkg::SCALE_W-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sfrsd_pkg::RAW_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sfrsd_pkg::CH_W-1:0]         channel,
    output logic [sfrsd_pkg::RAW_W-1:0]        raw_reading,
    output logic [sfrsd_pkg::Q4_W-1:0]         distance_q4,
    output logic                               last_of_frame
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [sfrsd_pkg::CH_W-1:0] CH_CNT  = sfrsd_pkg::CH_W'(CHANNELS);
    localparam logic [sfrsd_pkg::CH_W-1:0] CH_LAST = sfrsd_pkg::CH_W'(CHANNELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [sfrsd_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [sfrsd_pkg::Q4_W-1:0]    offset_reg, offset_next;
    logic [sfrsd_pkg::Q4_W-1:0]    limit_reg, limit_next;

    logic                          active_reg, active_next;
    logic [sfrsd_pkg::CH_W-1:0]    count_reg, count_next;
    logic [sfrsd_pkg::RAW_W-1:0]   sum_reg, sum_next;
    logic                          any_reg, any_next;
    logic [sfrsd_pkg::CH_W-1:0]    last_idx_reg, last_idx_next;
    logic [sfrsd_pkg::CH_W-1:0]    idx_reg, idx_next;

    logic [sfrsd_pkg::CH_W-1:0]    channel_reg, channel_next;
    logic [sfrsd_pkg::RAW_W-1:0]   raw_reg, raw_next;
    logic [sfrsd_pkg::Q4_W-1:0]    dist_reg, dist_next;
    logic                          last_reg, last_next;

    logic [sfrsd_pkg::RAW_W-1:0]   store [CHANNELS];
    logic [sfrsd_pkg::RAW_W-1:0]   rd_data_reg;

    logic                              in_fire;
    logic                              store_we;
    logic [sfrsd_pkg::RAW_W-1:0]       expect_sum;
    logic                              div_start;
    logic                              div_done;
    logic [sfrsd_pkg::DIVIDEND_W-1:0]  div_quotient;
    logic [sfrsd_pkg::DIVIDEND_W-1:0]  offset_ext;
    logic [sfrsd_pkg::DIVIDEND_W-1:0]  limit_ext;
    logic [sfrsd_pkg::DIVIDEND_W-1:0]  q_diff;
    logic [sfrsd_pkg::Q4_W-1:0]        dist_calc;

    sfrsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({scale_reg, 4'b0000}),
        .divisor  (rd_data_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign store_we = in_fire && (rx_byte != sfrsd_pkg::SYNC_BYTE) && active_reg
                      && (count_reg < CH_CNT);
    assign expect_sum = (sum_reg == sfrsd_pkg::SYNC_BYTE) ? '0 : sum_reg;
    assign div_start  = (state_reg == ST_CHECK) && (rd_data_reg != sfrsd_pkg::SKIP_RAW)
                        && (rd_data_reg != '0);

    always_comb
    begin
        offset_ext = {{(sfrsd_pkg::DIVIDEND_W - sfrsd_pkg::Q4_W){1'b0}}, offset_reg};
        limit_ext  = {{(sfrsd_pkg::DIVIDEND_W - sfrsd_pkg::Q4_W){1'b0}}, limit_reg};
        q_diff     = div_quotient - offset_ext;
        if (div_quotient <= offset_ext)
            dist_calc = '0;
        else if (q_diff > limit_ext)
            dist_calc = limit_reg;
        else
            dist_calc = q_diff[sfrsd_pkg::Q4_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        offset_next   = offset_reg;
        limit_next    = limit_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        any_next      = any_reg;
        last_idx_next = last_idx_reg;
        idx_next      = idx_reg;
        channel_next  = channel_reg;
        raw_next      = raw_reg;
        dist_next     = dist_reg;
        last_next     = last_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                sfrsd_pkg::CFG_SCALE:  scale_next  = cfg_data;
                sfrsd_pkg::CFG_OFFSET: offset_next = cfg_data[sfrsd_pkg::Q4_W-1:0];
                sfrsd_pkg::CFG_LIMIT:  limit_next  = cfg_data[sfrsd_pkg::Q4_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (rx_byte == sfrsd_pkg::SYNC_BYTE)
                    begin
                        active_next = 1'b1;
                        count_next  = '0;
                        sum_next    = '0;
                        any_next    = 1'b0;
                    end
                    else if (active_reg)
                    begin
                        if (count_reg < CH_CNT)
                        begin
                            sum_next   = sum_reg + rx_byte;
                            count_next = count_reg + 1'b1;
                            if (rx_byte != sfrsd_pkg::SKIP_RAW)
                            begin
                                any_next      = 1'b1;
                                last_idx_next = count_reg;
                            end
                        end
                        else
                        begin
                            active_next = 1'b0;
                            count_next  = '0;
                            sum_next    = '0;
                            if ((expect_sum == rx_byte) && any_reg)
                            begin
                                idx_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                channel_next = idx_reg;
                raw_next     = rd_data_reg;
                last_next    = (idx_reg == last_idx_reg);
                if (rd_data_reg == sfrsd_pkg::SKIP_RAW)
                begin
                    if (idx_reg == CH_LAST)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (rd_data_reg == '0)
                begin
                    dist_next  = limit_reg;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    dist_next  = dist_calc;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scale_reg    <= sfrsd_pkg::SCALE_RST;
            offset_reg   <= sfrsd_pkg::OFFSET_RST;
            limit_reg    <= sfrsd_pkg::LIMIT_RST;
            active_reg   <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            any_reg      <= 1'b0;
            last_idx_reg <= '0;
            idx_reg      <= '0;
            channel_reg  <= '0;
            raw_reg      <= '0;
            dist_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scale_reg    <= scale_next;
            offset_reg   <= offset_next;
            limit_reg    <= limit_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            any_reg      <= any_next;
            last_idx_reg <= last_idx_next;
            idx_reg      <= idx_next;
            channel_reg  <= channel_next;
            raw_reg      <= raw_next;
            dist_reg     <= dist_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store[count_reg[IDX_W-1:0]] <= rx_byte;
        if (state_reg == ST_READ)
            rd_data_reg <= store[idx_reg[IDX_W-1:0]];
    end

    assign out_valid     = (state_reg == ST_OUT);
    assign channel       = channel_reg;
    assign raw_reading   = raw_reg;
    assign distance_q4   = dist_reg;
    assign last_of_frame = last_reg;

endmodule

// File: src/sfrsd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module sfrsd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sfrsd_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [sfrsd_pkg::RAW_W-1:0]       divisor,
    output logic                              done,
    output logic [sfrsd_pkg::DIVIDEND_W-1:0]  quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [sfrsd_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [sfrsd_pkg::RAW_W-1:0]      rem_reg, rem_next;
    logic [sfrsd_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [sfrsd_pkg::RAW_W-1:0]      dvs_reg, dvs_next;

    logic [sfrsd_pkg::RAW_W:0] trial;
    logic [sfrsd_pkg::RAW_W:0] diff;
    logic                      fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[sfrsd_pkg::DIVIDEND_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[sfrsd_pkg::RAW_W-1:0] : trial[sfrsd_pkg::RAW_W-1:0];
            quo_next  = {quo_reg[sfrsd_pkg::DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == sfrsd_pkg::STEP_W'(sfrsd_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: verif/testbench.sv
// Testbench for the sync-framed range sensor decoder with a frame predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CH      = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 300;
    localparam int PHASE_BYTES = 40;
    localparam int NUM_PHASES  = 6;
    localparam int SCRIPT_LEN  = 27;

    typedef struct packed {
        logic [sfrsd_pkg::CH_W-1:0]  chan;
        logic [sfrsd_pkg::RAW_W-1:0] raw;
        logic [sfrsd_pkg::Q4_W-1:0]  dist_q4;
        logic                        is_last;
    } report_t;

    typedef struct packed {
        logic [sfrsd_pkg::RAW_W-1:0] rx;
        logic [1:0]                  n_typed;
        report_t                     rep_a;
        report_t                     rep_b;
    } script_row_t;

    typedef enum {GOOD_FRAME, SKIP_FRAME, BAD_SUM_FRAME, CUT_FRAME, LINE_NOISE} burst_t;

    localparam report_t NO_REP = '0;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [sfrsd_pkg::CFG_IDX_W-1:0] cfg_index = sfrsd_pkg::CFG_SCALE;
    logic [sfrsd_pkg::SCALE_W-1:0]   cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [sfrsd_pkg::RAW_W-1:0]     rx_byte   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sfrsd_pkg::CH_W-1:0]      channel;
    logic [sfrsd_pkg::RAW_W-1:0]     raw_reading;
    logic [sfrsd_pkg::Q4_W-1:0]      distance_q4;
    logic                            last_of_frame;

    logic [sfrsd_pkg::SCALE_W-1:0] scale_reg  = sfrsd_pkg::SCALE_RST;
    logic [sfrsd_pkg::Q4_W-1:0]    offset_reg = sfrsd_pkg::OFFSET_RST;
    logic [sfrsd_pkg::Q4_W-1:0]    limit_reg  = sfrsd_pkg::LIMIT_RST;
    logic                          frame_on   = 1'b0;
    int unsigned                   byte_idx   = 0;
    logic [sfrsd_pkg::RAW_W-1:0]   byte_sum   = '0;
    logic [sfrsd_pkg::RAW_W-1:0]   raw_store [NUM_CH];

    report_t     pending_reports [$];
    int          fail_count    = 0;
    int unsigned fed_count     = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    script_row_t script [SCRIPT_LEN] = '{
        {8'h2A,                 2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SYNC_BYTE,  2'd0, NO_REP, NO_REP},
        {8'h12,                 2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SYNC_BYTE,  2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h01,                 2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {sfrsd_pkg::SKIP_RAW,   2'd0, NO_REP, NO_REP},
        {8'd81,                 2'd2,
         {4'd0, 8'd0, sfrsd_pkg::LIMIT_RST, 1'b0},
         {4'd1, 8'd1, sfrsd_pkg::LIMIT_RST, 1'b1}},
        {sfrsd_pkg::SYNC_BYTE,  2'd0, NO_REP, NO_REP},
        {8'hFE,                 2'd0, NO_REP, NO_REP},
        {8'h01,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP},
        {8'h00,                 2'd0, NO_REP, NO_REP}
    };

    sync_framed_range_sensor_decoder_core #(
        .CHANNELS(NUM_CH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .channel(channel),
        .raw_reading(raw_reading),
        .distance_q4(distance_q4),
        .last_of_frame(last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= stall_pct);

    function automatic logic [sfrsd_pkg::Q4_W-1:0] range_q4(
        input logic [sfrsd_pkg::RAW_W-1:0] raw);
        logic [sfrsd_pkg::DIVIDEND_W-1:0] quot;
        if (raw == '0)
            return limit_reg;
        quot = {scale_reg, 4'b0000} / sfrsd_pkg::DIVIDEND_W'(raw);
        if (quot <= sfrsd_pkg::DIVIDEND_W'(offset_reg))
            return '0;
        quot = quot - sfrsd_pkg::DIVIDEND_W'(offset_reg);
        if (quot > sfrsd_pkg::DIVIDEND_W'(limit_reg))
            return limit_reg;
        return quot[sfrsd_pkg::Q4_W-1:0];
    endfunction

    function automatic void decode_byte(input logic [sfrsd_pkg::RAW_W-1:0] b,
                                        input logic enqueue);
        logic [sfrsd_pkg::RAW_W-1:0] want;
        report_t                     rep;
        int                          last_idx;
        int                          i;
        if (b == sfrsd_pkg::SYNC_BYTE)
        begin
            frame_on = 1'b1;
            byte_idx = 0;
            byte_sum = '0;
            fed_count++;
            return;
        end
        if (!frame_on)
            return;
        fed_count++;
        if (byte_idx < NUM_CH)
        begin
            raw_store[byte_idx] = b;
            byte_sum = byte_sum + b;
            byte_idx++;
            return;
        end
        want = (byte_sum == sfrsd_pkg::SYNC_BYTE) ? '0 : byte_sum;
        frame_on = 1'b0;
        byte_idx = 0;
        byte_sum = '0;
        if (!enqueue || want != b)
            return;
        last_idx = -1;
        for (i = 0; i < NUM_CH; i++)
            if (raw_store[i] != sfrsd_pkg::SKIP_RAW)
                last_idx = i;
        for (i = 0; i < NUM_CH; i++)
        begin
            if (raw_store[i] != sfrsd_pkg::SKIP_RAW)
            begin
                rep.chan    = sfrsd_pkg::CH_W'(i);
                rep.raw     = raw_store[i];
                rep.dist_q4 = range_q4(raw_store[i]);
                rep.is_last = (i == last_idx);
                pending_reports.push_back(rep);
            end
        end
    endfunction

    function automatic logic [sfrsd_pkg::RAW_W-1:0] pick_raw();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'd0;
        if (r < 16)
            return sfrsd_pkg::SKIP_RAW;
        if (r < 20)
            return 8'd1;
        if (r < 24)
            return 8'hFE;
        return sfrsd_pkg::RAW_W'($urandom_range(0, 254));
    endfunction

    task automatic send_byte(input logic [sfrsd_pkg::RAW_W-1:0] b, input logic enqueue);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b, enqueue);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic write_regs(input logic [sfrsd_pkg::SCALE_W-1:0] scale,
                              input logic [sfrsd_pkg::Q4_W-1:0] offset,
                              input logic [sfrsd_pkg::Q4_W-1:0] lim);
        logic [sfrsd_pkg::SCALE_W-1:0]   vals [3];
        logic [sfrsd_pkg::CFG_IDX_W-1:0] idx [3];
        int                              k;
        vals[0] = scale;
        vals[1] = sfrsd_pkg::SCALE_W'(offset);
        vals[2] = sfrsd_pkg::SCALE_W'(lim);
        idx[0]  = sfrsd_pkg::CFG_SCALE;
        idx[1]  = sfrsd_pkg::CFG_OFFSET;
        idx[2]  = sfrsd_pkg::CFG_LIMIT;
        for (k = 0; k < 3; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_write  <= 1'b0;
        scale_reg  = scale;
        offset_reg = offset;
        limit_reg  = lim;
    endtask

    task automatic send_burst(input burst_t kind);
        logic [sfrsd_pkg::RAW_W-1:0] body [NUM_CH];
        logic [sfrsd_pkg::RAW_W-1:0] sum;
        logic [sfrsd_pkg::RAW_W-1:0] tail;
        logic [sfrsd_pkg::RAW_W-1:0] bad;
        int                          n;
        int                          k;
        if (kind == LINE_NOISE)
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send_byte(sfrsd_pkg::RAW_W'($urandom_range(0, 255)), 1'b1);
            return;
        end
        sum = '0;
        for (k = 0; k < NUM_CH; k++)
        begin
            body[k] = (kind == SKIP_FRAME) ? sfrsd_pkg::SKIP_RAW : pick_raw();
            sum = sum + body[k];
        end
        n = (kind == CUT_FRAME) ? $urandom_range(0, NUM_CH - 1) : NUM_CH;
        send_byte(sfrsd_pkg::SYNC_BYTE, 1'b1);
        for (k = 0; k < n; k++)
            send_byte(body[k], 1'b1);
        if (kind == CUT_FRAME)
            return;
        tail = (sum == sfrsd_pkg::SYNC_BYTE) ? '0 : sum;
        if (kind == BAD_SUM_FRAME)
        begin
            do
                bad = sfrsd_pkg::RAW_W'($urandom_range(0, 254));
            while (bad == tail);
            tail = bad;
        end
        send_byte(tail, 1'b1);
    endtask

    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected transfer: channel %0d raw_reading %0d distance_q4 %0d",
                       channel, raw_reading, distance_q4);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (channel !== want.chan)
                begin
                    $error("channel: expected %0d, got %0d", want.chan, channel);
                    fail_count++;
                end
                if (raw_reading !== want.raw)
                begin
                    $error("raw_reading: expected %0d, got %0d", want.raw, raw_reading);
                    fail_count++;
                end
                if (distance_q4 !== want.dist_q4)
                begin
                    $error("distance_q4: expected %0d, got %0d", want.dist_q4, distance_q4);
                    fail_count++;
                end
                if (last_of_frame !== want.is_last)
                begin
                    $error("last_of_frame: expected %0d, got %0d", want.is_last, last_of_frame);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          row;
        int unsigned start;
        int unsigned r;
        burst_t      kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < SCRIPT_LEN; row++)
        begin
            send_byte(script[row].rx, script[row].n_typed == 2'd0);
            if (script[row].n_typed > 2'd0)
                pending_reports.push_back(script[row].rep_a);
            if (script[row].n_typed > 2'd1)
                pending_reports.push_back(script[row].rep_b);
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // hold off until the scan sequencer is done before touching registers
            hold_until_drained();
            repeat (SETTLE) @(posedge clk);
            case (ph)
                0:
                begin
                    write_regs(16'hFFFF, 12'd0, 12'hFFF);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    write_regs(16'd1, 12'hFFF, 12'hFFF);
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                2:
                begin
                    write_regs(16'hFFFF, 12'hFFF, 12'd0);
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
                3:
                begin
                    write_regs(sfrsd_pkg::SCALE_W'($urandom_range(1, 65535)),
                               sfrsd_pkg::Q4_W'($urandom_range(0, 300)),
                               sfrsd_pkg::Q4_W'($urandom_range(100, 4095)));
                    send_idle_pct = 24;
                    stall_pct     = 24;
                end
                4:
                begin
                    write_regs(sfrsd_pkg::SCALE_RST, sfrsd_pkg::OFFSET_RST,
                               sfrsd_pkg::LIMIT_RST);
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                default:
                begin
                    write_regs(sfrsd_pkg::SCALE_W'($urandom_range(1, 65535)),
                               sfrsd_pkg::Q4_W'($urandom_range(0, 4095)),
                               sfrsd_pkg::Q4_W'($urandom_range(0, 4095)));
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
            endcase

            start = fed_count;
            while (fed_count - start < PHASE_BYTES)
            begin
                if ($urandom_range(19) == 0)
                    hold_until_drained();
                r = $urandom_range(99);
                if (r < 60)
                    kind = GOOD_FRAME;
                else if (r < 66)
                    kind = SKIP_FRAME;
                else if (r < 80)
                    kind = BAD_SUM_FRAME;
                else if (r < 90)
                    kind = CUT_FRAME;
                else
                    kind = LINE_NOISE;
                send_burst(kind);
            end
        end

        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
